>>> design/pkset_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkset_pkg
// Shared types and constants for the pressed key set tracker.
// ----------------------------------------------------------------------------
package pkset_pkg;

   localparam int SLOT_COUNT_DEF = 16;
   localparam int CODE_W         = 16;
   localparam int POS_W          = 16;
   localparam int OP_W           = 3;
   localparam int CSR_IDX_W      = 1;

   // operation codes
   localparam logic [OP_W-1:0] OP_PRESS      = 3'd0;
   localparam logic [OP_W-1:0] OP_RELEASE    = 3'd1;
   localparam logic [OP_W-1:0] OP_WHEEL_UP   = 3'd2;
   localparam logic [OP_W-1:0] OP_WHEEL_DOWN = 3'd3;
   localparam logic [OP_W-1:0] OP_OTHER      = 3'd4;
   localparam logic [OP_W-1:0] OP_MOVE       = 3'd5;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_UP   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_DOWN = 1'd1;

   // divide by five: floor(a / 5) == (a * 52429) >> 18 for every a below 2**18
   localparam int               DIV5_MAG_W  = 18;
   localparam int               DIV5_SHIFT  = 18;
   localparam logic [15:0]      DIV5_RECIP  = 16'd52429;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic [CODE_W-1:0]        key_code;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
   } req_payload_type;

   typedef struct packed {
      logic                     any_pressed;
      logic                     table_full;
      logic signed [POS_W-1:0]  smooth_x;
      logic signed [POS_W-1:0]  smooth_y;
   } rsp_payload_type;

endpackage

>>> design/pkset_smooth.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkset_smooth
// Two-stage pointer smoother: (4*prev + now + 4) / 5, truncating toward zero.
// ----------------------------------------------------------------------------
module pkset_smooth (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_vld,
   input  logic signed [pkset_pkg::POS_W-1:0] prev,
   input  logic signed [pkset_pkg::POS_W-1:0] now,
   output logic                              out_vld,
   output logic signed [pkset_pkg::POS_W-1:0] result
);
   import pkset_pkg::*;

   localparam int NUM_W  = POS_W + 3;
   localparam int PROD_W = DIV5_MAG_W + 16;

   logic signed [NUM_W-1:0]  num;
   logic                     neg;
   logic [NUM_W-1:0]         num_abs;

   logic                     vld1_ff;
   logic                     neg1_ff;
   logic [DIV5_MAG_W-1:0]    mag_ff;
   logic                     vld2_ff;
   logic                     neg2_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [PROD_W-1:0]        prod_in;
   logic [POS_W-1:0]         quot;

   always_comb begin
      num     = $signed({prev[POS_W-1], prev, 2'b00})
              + $signed({{3{now[POS_W-1]}}, now})
              + NUM_W'(4);
      neg     = num[NUM_W-1];
      num_abs = neg ? NUM_W'(-num) : NUM_W'(num);
      prod_in = {{(PROD_W-DIV5_MAG_W){1'b0}}, mag_ff}
              * {{(PROD_W-16){1'b0}}, DIV5_RECIP};
      quot    = prod_ff[DIV5_SHIFT +: POS_W];
      result  = neg2_ff ? $signed(POS_W'(-quot)) : $signed(quot);
      out_vld = vld2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
      end
      neg1_ff <= neg;
      mag_ff  <= num_abs[DIV5_MAG_W-1:0];
      neg2_ff <= neg1_ff;
      prod_ff <= prod_in;
   end

endmodule

>>> design/pressed_key_set_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressed_key_set_tracker_unit
// Tracks the set of pressed codes in a slot table and smooths pointer moves.
// ----------------------------------------------------------------------------
//  channel | ports              | beat
//  --------+--------------------+-----------------------------------------
//  request | req_valid/ready    | operation, key code, pointer position
//  result  | rsp_valid/ready    | any pressed, table full, smoothed x/y
//  config  | csr_write_en       | wheel up / wheel down code, no wait
//
//  A beat runs from accept through a scan of the slot table, which has one
//  read port and is scanned one slot a cycle; a move then runs x and y
//  through the shared two-stage smoother. A result waiting in the output
//  register holds only the final step; the next request is taken meanwhile.
//  Synchronous reset empties the table at once through the occupancy bits.
// ----------------------------------------------------------------------------
module pressed_key_set_tracker_unit #(
   parameter int SLOT_COUNT = pkset_pkg::SLOT_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pkset_pkg::req_payload_type           req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pkset_pkg::rsp_payload_type           rsp_payload,
   input  logic                                 csr_write_en,
   input  logic [pkset_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pkset_pkg::CODE_W-1:0]         csr_wdata
);
   import pkset_pkg::*;

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_PUT  = 3'd2;
   localparam logic [2:0] S_SMX  = 3'd3;
   localparam logic [2:0] S_SMY  = 3'd4;
   localparam logic [2:0] S_SMW  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic [CODE_W-1:0]       code_ff, code_in;
   logic signed [POS_W-1:0] pos_x_ff, pos_x_in;
   logic signed [POS_W-1:0] pos_y_ff, pos_y_in;
   logic [CODE_W-1:0]       wup_ff, wup_in;
   logic [CODE_W-1:0]       wdn_ff, wdn_in;
   logic [SLOT_COUNT-1:0]   occ_ff, occ_in;
   logic [CNT_W-1:0]        issue_ff, issue_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                    dup_ff, dup_in;
   logic                    ddn_ff, ddn_in;
   logic                    drel_ff, drel_in;
   logic                    found_ff, found_in;
   logic                    free_ok_ff, free_ok_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic                    full_ff, full_in;
   logic signed [POS_W-1:0] cursor_x_ff, cursor_x_in;
   logic signed [POS_W-1:0] cursor_y_ff, cursor_y_in;
   logic signed [POS_W-1:0] filt_x_ff, filt_x_in;
   logic signed [POS_W-1:0] filt_y_ff, filt_y_in;
   logic                    ysel_ff, ysel_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_payload_ff, rsp_payload_in;

   logic [CODE_W-1:0]       mem [SLOT_COUNT];
   logic [CODE_W-1:0]       rd_data_ff;
   logic                    mem_re;
   logic                    mem_we;

   logic                    is_put;
   logic                    is_rel;
   logic [CODE_W-1:0]       put_code;
   logic [CODE_W-1:0]       v0, v1, v2, v3;
   logic                    hit_up, hit_dn, hit_rel;

   logic                    sm_in_vld;
   logic signed [POS_W-1:0] sm_prev, sm_now;
   logic                    sm_out_vld;
   logic signed [POS_W-1:0] sm_result;

   pkset_smooth u_smooth (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (sm_in_vld),
      .prev    (sm_prev),
      .now     (sm_now),
      .out_vld (sm_out_vld),
      .result  (sm_result)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign is_put = (op_ff == OP_PRESS) || (op_ff == OP_WHEEL_UP) || (op_ff == OP_WHEEL_DOWN);
   assign is_rel = (op_ff == OP_RELEASE);

   always_comb begin
      unique case (op_ff)
         OP_WHEEL_UP:   put_code = wup_ff;
         OP_WHEEL_DOWN: put_code = wdn_ff;
         default:       put_code = code_ff;
      endcase
   end

   // wheel codes drop first, then the release; each takes only its first match
   always_comb begin
      v0      = occ_ff[cmp_idx_ff] ? rd_data_ff : '0;
      hit_up  = !dup_ff && (v0 == wup_ff);
      v1      = hit_up ? '0 : v0;
      hit_dn  = !ddn_ff && (v1 == wdn_ff);
      v2      = hit_dn ? '0 : v1;
      hit_rel = is_rel && !drel_ff && (v2 == code_ff);
      v3      = hit_rel ? '0 : v2;
   end

   assign mem_re = (state_ff == S_SCAN) && (issue_ff < CNT_W'(SLOT_COUNT));
   assign mem_we = (state_ff == S_PUT) && is_put && !found_ff && free_ok_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[free_idx_ff] <= put_code;
      end
      if (mem_re) begin
         rd_data_ff <= mem[issue_ff[IDX_W-1:0]];
      end
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      code_in        = code_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      wup_in         = wup_ff;
      wdn_in         = wdn_ff;
      occ_in         = occ_ff;
      issue_in       = issue_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      dup_in         = dup_ff;
      ddn_in         = ddn_ff;
      drel_in        = drel_ff;
      found_in       = found_ff;
      free_ok_in     = free_ok_ff;
      free_idx_in    = free_idx_ff;
      full_in        = full_ff;
      cursor_x_in    = cursor_x_ff;
      cursor_y_in    = cursor_y_ff;
      filt_x_in      = filt_x_ff;
      filt_y_in      = filt_y_ff;
      ysel_in        = ysel_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      sm_in_vld      = 1'b0;
      sm_prev        = cursor_x_ff;
      sm_now         = pos_x_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_WHEEL_UP:   wup_in = csr_wdata;
            CSR_WHEEL_DOWN: wdn_in = csr_wdata;
         endcase
      end

      // compare stage works on the read issued in the cycle before
      if (cmp_vld_ff) begin
         if (hit_up) dup_in = 1'b1;
         if (hit_dn) ddn_in = 1'b1;
         if (hit_rel) drel_in = 1'b1;
         occ_in[cmp_idx_ff] = (v3 != '0);
         if (is_put) begin
            if (v2 == put_code) found_in = 1'b1;
            if ((v2 == '0) && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = cmp_idx_ff;
            end
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_payload.operation;
               code_in    = req_payload.key_code;
               pos_x_in   = req_payload.pos_x;
               pos_y_in   = req_payload.pos_y;
               issue_in   = '0;
               dup_in     = 1'b0;
               ddn_in     = 1'b0;
               drel_in    = 1'b0;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
               full_in    = 1'b0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (mem_re) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[IDX_W-1:0];
               issue_in   = issue_ff + CNT_W'(1);
            end else begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            if (is_put && !found_ff) begin
               if (free_ok_ff) begin
                  occ_in[free_idx_ff] = 1'b1;
               end else begin
                  full_in = 1'b1;
               end
            end
            if (op_ff == OP_CLEAR) begin
               occ_in = '0;
            end
            state_in = (op_ff == OP_MOVE) ? S_SMX : S_DONE;
         end
         S_SMX: begin
            sm_in_vld = 1'b1;
            ysel_in   = 1'b0;
            state_in  = S_SMY;
         end
         S_SMY: begin
            sm_in_vld = 1'b1;
            sm_prev   = cursor_y_ff;
            sm_now    = pos_y_ff;
            state_in  = S_SMW;
         end
         S_SMW: begin
            if (sm_out_vld) begin
               if (!ysel_ff) begin
                  filt_x_in = sm_result;
                  ysel_in   = 1'b1;
               end else begin
                  filt_y_in   = sm_result;
                  cursor_x_in = pos_x_ff;
                  cursor_y_in = pos_y_ff;
                  state_in    = S_DONE;
               end
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_payload_in.any_pressed = |occ_ff;
               rsp_payload_in.table_full  = full_ff;
               rsp_payload_in.smooth_x    = filt_x_ff;
               rsp_payload_in.smooth_y    = filt_y_ff;
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wup_ff       <= '0;
         wdn_ff       <= '0;
         occ_ff       <= '0;
         issue_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         dup_ff       <= 1'b0;
         ddn_ff       <= 1'b0;
         drel_ff      <= 1'b0;
         found_ff     <= 1'b0;
         free_ok_ff   <= 1'b0;
         full_ff      <= 1'b0;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         filt_x_ff    <= '0;
         filt_y_ff    <= '0;
         ysel_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wup_ff       <= wup_in;
         wdn_ff       <= wdn_in;
         occ_ff       <= occ_in;
         issue_ff     <= issue_in;
         cmp_vld_ff   <= cmp_vld_in;
         dup_ff       <= dup_in;
         ddn_ff       <= ddn_in;
         drel_ff      <= drel_in;
         found_ff     <= found_in;
         free_ok_ff   <= free_ok_in;
         full_ff      <= full_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         filt_x_ff    <= filt_x_in;
         filt_y_ff    <= filt_y_in;
         ysel_ff      <= ysel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      code_ff        <= code_in;
      pos_x_ff       <= pos_x_in;
      pos_y_ff       <= pos_y_in;
      cmp_idx_ff     <= cmp_idx_in;
      free_idx_ff    <= free_idx_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

>>> design/pkset_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkset_checker
// Port-level checks on the pressed key set tracker, bound to the top level.
// ----------------------------------------------------------------------------
module pkset_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input pkset_pkg::rsp_payload_type           rsp_payload
);
   import pkset_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // the block is busy as the scan starts after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("request taken during a scan");

   // a dropped add means every slot is taken
   a_full_implies_pressed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.table_full |-> rsp_payload.any_pressed)
      else $error("table full reported with no pressed code");

   // reset leaves the block idle with no result
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind pressed_key_set_tracker_unit pkset_checker u_pkset_checker (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pressed key set tracker unit. A short scripted
// run covers the corner cases: empty and full table, code zero, absent
// releases and wheel codes. Several random phases follow, each under its own
// pair of wheel codes. A local model of the slot table and the pointer
// smoother predicts beats with no scripted value. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
   import pkset_pkg::*;

   localparam int              SLOT_COUNT  = SLOT_COUNT_DEF;
   localparam int              CYCLE_LIMIT = 400000;
   localparam int              PHASE_BEATS = 100;
   localparam logic [OP_W-1:0] OP_UNUSED   = 3'd7;

   typedef struct {
      bit                        csr;
      logic [CSR_IDX_W-1:0]      idx;
      logic [CODE_W-1:0]         data;
      int                        count;
      req_payload_type           ev;
      bit                        typed;
      rsp_payload_type           want;
   } script_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_payload_type       rsp_payload;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CODE_W-1:0]     csr_wdata;

   // model state
   logic [CODE_W-1:0]       slot_codes [SLOT_COUNT];
   logic signed [POS_W-1:0] ptr_x, ptr_y, avg_x, avg_y;
   logic [CODE_W-1:0]       wheel_up_q, wheel_down_q;

   rsp_payload_type status_q [$];
   script_row_type  script [$];
   int              errors;
   int              cycles;
   bit              req_calm;
   bit              rsp_calm;

   pressed_key_set_tracker_unit #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, status_q.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- model

   function automatic void free_first(logic [CODE_W-1:0] code);
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (slot_codes[i] == code) begin
            slot_codes[i] = '0;
            return;
         end
      end
   endfunction

   // returns 1 when the code is absent and no slot is free
   function automatic logic add_code(logic [CODE_W-1:0] code);
      for (int i = 0; i < SLOT_COUNT; i++)
         if (slot_codes[i] == code)
            return 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (slot_codes[i] == '0) begin
            slot_codes[i] = code;
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // (4*last + now + 4) / 5, truncating toward zero
   function automatic logic signed [POS_W-1:0] ease(logic signed [POS_W-1:0] last,
                                                    logic signed [POS_W-1:0] now);
      int acc;
      acc = int'(last) * 4 + int'(now) + 4;
      return POS_W'(acc / 5);
   endfunction

   function automatic rsp_payload_type track_event(req_payload_type ev);
      rsp_payload_type res;
      logic            full;
      full = 1'b0;
      free_first(wheel_up_q);
      free_first(wheel_down_q);
      case (ev.operation)
         OP_PRESS:      full = add_code(ev.key_code);
         OP_RELEASE:    free_first(ev.key_code);
         OP_WHEEL_UP:   full = add_code(wheel_up_q);
         OP_WHEEL_DOWN: full = add_code(wheel_down_q);
         OP_MOVE: begin
            avg_x = ease(ptr_x, ev.pos_x);
            avg_y = ease(ptr_y, ev.pos_y);
            ptr_x = ev.pos_x;
            ptr_y = ev.pos_y;
         end
         OP_CLEAR: begin
            foreach (slot_codes[i])
               slot_codes[i] = '0;
         end
         default: ;
      endcase
      res.any_pressed = 1'b0;
      foreach (slot_codes[i])
         if (slot_codes[i] != '0)
            res.any_pressed = 1'b1;
      res.table_full = full;
      res.smooth_x   = avg_x;
      res.smooth_y   = avg_y;
      return res;
   endfunction

   // ------------------------------------------------------------- stimulus

   function automatic int idle_cycles(bit calm);
      return calm ? 0 : int'($urandom_range(0, 14));
   endfunction

   function automatic void add_step(logic [OP_W-1:0] op, logic [CODE_W-1:0] code,
                                    logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                    int count, bit typed, logic any, logic full);
      script_row_type row;
      row.csr   = 1'b0;
      row.idx   = CSR_WHEEL_UP;
      row.data  = '0;
      row.count = count;
      row.ev    = '{operation: op, key_code: code, pos_x: x, pos_y: y};
      row.typed = typed;
      row.want  = '{any_pressed: any, table_full: full, smooth_x: '0, smooth_y: '0};
      script.push_back(row);
   endfunction

   function automatic void add_csr(logic [CSR_IDX_W-1:0] idx, logic [CODE_W-1:0] data);
      script_row_type row;
      row.csr   = 1'b1;
      row.idx   = idx;
      row.data  = data;
      row.count = 0;
      row.ev    = '0;
      row.typed = 1'b0;
      row.want  = '0;
      script.push_back(row);
   endfunction

   task automatic send_event(req_payload_type ev, bit use_typed, rsp_payload_type typed_want);
      rsp_payload_type predicted;
      int              gap;
      if ($urandom_range(0, 39) == 0)
         req_calm = !req_calm;
      gap = idle_cycles(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= ev;
      do @(posedge clock); while (!req_ready);
      predicted = track_event(ev);
      status_q.push_back(use_typed ? typed_want : predicted);
   endtask

   // hold the request side until every result beat is back
   task automatic settle_block();
      req_valid <= 1'b0;
      while (status_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CODE_W-1:0] data);
      settle_block();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      if (idx == CSR_WHEEL_UP)
         wheel_up_q = data;
      else if (idx == CSR_WHEEL_DOWN)
         wheel_down_q = data;
      csr_write_en <= 1'b0;
   endtask

   // ------------------------------------------------------------- checking

   function automatic bit field_ok(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   initial begin : rsp_side
      rsp_payload_type got;
      rsp_payload_type want;
      int              stall;
      bit              ok;
      rsp_ready <= 1'b0;
      rsp_calm = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0)
            rsp_calm = !rsp_calm;
         stall = idle_cycles(rsp_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got = rsp_payload;
         if (status_q.size() == 0) begin
            $display("%0t: result beat with none outstanding, got %h", $time, got);
            errors++;
         end else begin
            want = status_q.pop_front();
            ok = field_ok("any_pressed", 16'(want.any_pressed), 16'(got.any_pressed));
            ok = field_ok("table_full", 16'(want.table_full), 16'(got.table_full)) && ok;
            ok = field_ok("smooth_x", want.smooth_x, got.smooth_x) && ok;
            ok = field_ok("smooth_y", want.smooth_y, got.smooth_y) && ok;
            if (!ok)
               errors++;
         end
      end
   end

   // ----------------------------------------------------------------- main

   initial begin : req_side
      req_payload_type ev;
      logic [CODE_W-1:0] up_code, down_code;
      int pool_top;
      int pick;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_payload  <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= CSR_WHEEL_UP;
      csr_wdata    <= '0;
      errors   = 0;
      req_calm = 1'b0;
      foreach (slot_codes[i])
         slot_codes[i] = '0;
      ptr_x = '0;
      ptr_y = '0;
      avg_x = '0;
      avg_y = '0;
      wheel_up_q   = '0;
      wheel_down_q = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // wheel codes are zero out of reset
      add_step(OP_OTHER,      16'h0000, '0, '0, 1, 1, 0, 0);
      add_step(OP_UNUSED,     16'hFFFF, '0, '0, 1, 1, 0, 0);
      add_step(OP_PRESS,      16'h0000, '0, '0, 1, 1, 0, 0);
      add_step(OP_WHEEL_UP,   16'h0000, '0, '0, 1, 1, 0, 0);
      add_step(OP_WHEEL_DOWN, 16'h0000, '0, '0, 1, 1, 0, 0);
      add_step(OP_RELEASE,    16'h1234, '0, '0, 1, 1, 0, 0);
      add_step(OP_RELEASE,    16'h0000, '0, '0, 1, 1, 0, 0);
      add_step(OP_PRESS,      16'hFFFF, '0, '0, 1, 1, 1, 0);
      add_step(OP_PRESS,      16'hFFFF, '0, '0, 1, 1, 1, 0);
      add_step(OP_RELEASE,    16'hFFFF, '0, '0, 1, 1, 0, 0);
      // fill every slot with codes 1 upwards, then push into the full table
      add_step(OP_PRESS,      16'h0001, '0, '0, SLOT_COUNT, 1, 1, 0);
      add_step(OP_PRESS,      16'h0000, '0, '0, 1, 1, 1, 1);
      add_step(OP_PRESS,      16'h8000, '0, '0, 1, 1, 1, 1);
      add_step(OP_PRESS,      16'h0005, '0, '0, 1, 1, 1, 0);
      add_step(OP_RELEASE,    16'h0003, '0, '0, 1, 1, 1, 0);
      add_step(OP_PRESS,      16'h0000, '0, '0, 1, 1, 1, 0);
      add_step(OP_CLEAR,      16'h0000, '0, '0, 1, 1, 0, 0);
      add_step(OP_MOVE,       16'h0000, 16'h7FFF, 16'h8000, 1, 0, 0, 0);
      add_step(OP_MOVE,       16'hFFFF, 16'h8000, 16'h7FFF, 1, 0, 0, 0);
      add_step(OP_MOVE,       16'h0000, 16'h0000, 16'h0000, 1, 0, 0, 0);
      add_step(OP_MOVE,       16'h0000, 16'hFFFF, 16'h0001, 1, 0, 0, 0);
      add_csr(CSR_WHEEL_UP,   16'hFFFF);
      add_csr(CSR_WHEEL_DOWN, 16'h8000);
      add_step(OP_WHEEL_UP,   16'h0000, '0, '0, 1, 0, 0, 0);
      add_step(OP_PRESS,      16'h8000, '0, '0, 1, 0, 0, 0);
      add_step(OP_OTHER,      16'h0000, '0, '0, 1, 0, 0, 0);
      add_step(OP_WHEEL_DOWN, 16'h0000, '0, '0, 1, 0, 0, 0);
      add_step(OP_WHEEL_UP,   16'h0000, '0, '0, 1, 0, 0, 0);
      add_step(OP_RELEASE,    16'hFFFF, '0, '0, 1, 0, 0, 0);

      foreach (script[r]) begin
         if (script[r].csr) begin
            write_csr(script[r].idx, script[r].data);
         end else begin
            for (int k = 0; k < script[r].count; k++) begin
               ev = script[r].ev;
               ev.key_code = ev.key_code + CODE_W'(k);
               send_event(ev, script[r].typed, script[r].want);
            end
         end
      end

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               up_code   = 16'h0000;
               down_code = 16'h0000;
            end
            1: begin
               up_code   = 16'hFFFF;
               down_code = 16'hFFFF;
            end
            2: begin
               up_code   = 16'hFFFF;
               down_code = 16'h0000;
            end
            3: begin
               up_code   = 16'h0003;
               down_code = 16'h0007;
            end
            4: begin
               up_code   = 16'h0005;
               down_code = 16'h0005;
            end
            default: begin
               up_code   = 16'($urandom);
               down_code = 16'($urandom);
            end
         endcase
         write_csr(CSR_WHEEL_UP, up_code);
         write_csr(CSR_WHEEL_DOWN, down_code);
         // a pool a little larger than the table keeps it near full
         pool_top = $urandom_range(SLOT_COUNT + 1, SLOT_COUNT + 12);
         repeat (PHASE_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      ev.operation = OP_PRESS;
            else if (pick < 63) ev.operation = OP_RELEASE;
            else if (pick < 69) ev.operation = OP_WHEEL_UP;
            else if (pick < 75) ev.operation = OP_WHEEL_DOWN;
            else if (pick < 79) ev.operation = OP_OTHER;
            else if (pick < 81) ev.operation = OP_UNUSED;
            else if (pick < 99) ev.operation = OP_MOVE;
            else                ev.operation = OP_CLEAR;
            pick = $urandom_range(0, 99);
            if (pick < 80)      ev.key_code = CODE_W'($urandom_range(1, pool_top));
            else if (pick < 86) ev.key_code = '0;
            else if (pick < 90) ev.key_code = wheel_up_q;
            else if (pick < 94) ev.key_code = wheel_down_q;
            else                ev.key_code = CODE_W'($urandom);
            if ($urandom_range(0, 9) == 0)
               ev.pos_x = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            else
               ev.pos_x = POS_W'($urandom);
            if ($urandom_range(0, 9) == 0)
               ev.pos_y = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            else
               ev.pos_y = POS_W'($urandom);
            send_event(ev, 1'b0, '0);
            if ($urandom_range(0, 149) == 0)
               settle_block();
         end
      end

      settle_block();
      repeat (30) @(posedge clock);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
